// ===== hdl/sfp_pkg.sv =====
// ---------------------------------------------------------------------------
// sfp_pkg
// shared types and constants of the sum8 command frame parser
// ---------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    localparam int CNT_OUT_W = 32;
    localparam int NUM_CNT   = 5;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_VALID    = 3'd1,
        ST_BAD_TAIL = 3'd2,
        ST_BAD_MSG  = 3'd3,
        ST_BAD_SUM  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_HDR1     = 3'd0,
        CFG_HDR2_RX  = 3'd1,
        CFG_HDR2_TX  = 3'd2,
        CFG_MSG_RX   = 3'd3,
        CFG_MSG_TX   = 3'd4,
        CFG_TAIL     = 3'd5
    } t_cfg_idx;

    localparam logic [7:0] RST_HDR1    = 8'h6B;
    localparam logic [7:0] RST_HDR2_RX = 8'h79;
    localparam logic [7:0] RST_HDR2_TX = 8'h6A;
    localparam logic [7:0] RST_MSG_RX  = 8'h81;
    localparam logic [7:0] RST_MSG_TX  = 8'h82;
    localparam logic [7:0] RST_TAIL    = 8'hFB;
    localparam logic [7:0] PAD_BYTE    = 8'h00;

    typedef struct packed {
        logic [7:0] hdr1;
        logic [7:0] hdr2_rx;
        logic [7:0] hdr2_tx;
        logic [7:0] msg_rx;
        logic [7:0] msg_tx;
        logic [7:0] tail;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [7:0] cmd;
    } t_job_ctl;

endpackage

`default_nettype wire

// ===== hdl/sum8_command_frame_parser.sv =====
// ---------------------------------------------------------------------------
// sum8_command_frame_parser
// parses 8-byte command frames with sum8 checksum and sends reply frames
// ---------------------------------------------------------------------------
//  channel   signals                                 direction
//  input     i_valid / o_ready, i_func, i_rx_byte    in
//  output    o_valid / i_ready, o_tx_byte .. counts  out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data         in, write only
//
//  a byte or clear passes through the checker combinationally and is queued (two entries)
//  the sequencer sends one transaction per cycle while i_ready is high: 1 per item, 8 per good frame
//  sustained rate is set by the sequencer
//  reset is synchronous, active low, with no clearing pass
//  input stalls only while the queue is full
// ---------------------------------------------------------------------------
`default_nettype none

module sum8_command_frame_parser #(
    parameter int COUNTER_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_func,
    input  wire logic [7:0]                    i_rx_byte,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [7:0]                         o_tx_byte,
    output logic                               o_tx_valid,
    output logic                               o_last,
    output logic [2:0]                         o_frame_status,
    output logic [7:0]                         o_command_id,
    output logic [sfp_pkg::CNT_OUT_W-1:0]      o_byte_count,
    output logic [sfp_pkg::CNT_OUT_W-1:0]      o_valid_count,
    output logic [sfp_pkg::CNT_OUT_W-1:0]      o_bad_tail_count,
    output logic [sfp_pkg::CNT_OUT_W-1:0]      o_bad_msg_count,
    output logic [sfp_pkg::CNT_OUT_W-1:0]      o_bad_sum_count,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_idx,
    input  wire logic [7:0]                    i_cfg_data
);
    import sfp_pkg::*;

    localparam int CntBits = NUM_CNT * COUNTER_WIDTH;
    localparam int JobW    = $bits(t_job_ctl) + CntBits;

    t_cfg             r_cfg;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_job_ctl         f_ctl;
    logic [CntBits-1:0] f_cnt;
    logic [JobW-1:0]  q_data;
    t_job_ctl         b_ctl;
    logic [CntBits-1:0] b_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr1    <= RST_HDR1;
            r_cfg.hdr2_rx <= RST_HDR2_RX;
            r_cfg.hdr2_tx <= RST_HDR2_TX;
            r_cfg.msg_rx  <= RST_MSG_RX;
            r_cfg.msg_tx  <= RST_MSG_TX;
            r_cfg.tail    <= RST_TAIL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HDR1:    r_cfg.hdr1    <= i_cfg_data;
                CFG_HDR2_RX: r_cfg.hdr2_rx <= i_cfg_data;
                CFG_HDR2_TX: r_cfg.hdr2_tx <= i_cfg_data;
                CFG_MSG_RX:  r_cfg.msg_rx  <= i_cfg_data;
                CFG_MSG_TX:  r_cfg.msg_tx  <= i_cfg_data;
                CFG_TAIL:    r_cfg.tail    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_ready = !q_full;
    assign push    = i_valid && !q_full;

    sfp_front #(
        .W (COUNTER_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_func    (i_func),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_ctl     (f_ctl),
        .o_cnt     (f_cnt)
    );

    sfp_queue #(
        .DATA_W (JobW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_cnt}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    assign b_ctl = q_data[JobW-1 -: $bits(t_job_ctl)];
    assign b_cnt = q_data[CntBits-1:0];

    sfp_back #(
        .W (COUNTER_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_job_valid      (q_valid),
        .i_job_ctl        (b_ctl),
        .i_job_cnt        (b_cnt),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_tx_byte        (o_tx_byte),
        .o_tx_valid       (o_tx_valid),
        .o_last           (o_last),
        .o_frame_status   (o_frame_status),
        .o_command_id     (o_command_id),
        .o_byte_count     (o_byte_count),
        .o_valid_count    (o_valid_count),
        .o_bad_tail_count (o_bad_tail_count),
        .o_bad_msg_count  (o_bad_msg_count),
        .o_bad_sum_count  (o_bad_sum_count)
    );

endmodule

`default_nettype wire

// ===== hdl/sfp_front.sv =====
// ---------------------------------------------------------------------------
// sfp_front
// byte hunter, frame checker and statistics counters
// ---------------------------------------------------------------------------
`default_nettype none

module sfp_front #(
    parameter int W = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    input  wire logic                               i_func,
    input  wire logic [7:0]                         i_rx_byte,
    input  wire sfp_pkg::t_cfg                      i_cfg,
    output sfp_pkg::t_job_ctl                       o_ctl,
    output logic [sfp_pkg::NUM_CNT*W-1:0]           o_cnt
);
    import sfp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_HEAD2 = 3'b010,
        PH_DATA  = 3'b100
    } t_phase;

    localparam logic [W-1:0] CntOne  = W'(1);
    localparam logic [W-1:0] CntZero = '0;
    localparam logic [2:0]   FillMsg = 3'd3;
    localparam logic [2:0]   FillCmd = 3'd4;
    localparam logic [2:0]   FillSum = 3'd5;
    localparam logic [2:0]   FillChk = 3'd6;
    localparam logic [2:0]   FillEnd = 3'd7;
    localparam logic [2:0]   FillFirst = 3'd2;

    t_phase     r_phase, n_phase;
    logic [2:0] r_fill, n_fill;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_msg, n_msg;
    logic [7:0] r_cmdb, n_cmdb;
    logic [7:0] r_chk, n_chk;
    logic [7:0] r_cmd, n_cmd;
    logic [W-1:0] r_bytes, n_bytes;
    logic [W-1:0] r_good, n_good;
    logic [W-1:0] r_tail, n_tail;
    logic [W-1:0] r_msgbad, n_msgbad;
    logic [W-1:0] r_sumbad, n_sumbad;
    t_status    status;

    always_comb begin
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_sum    = r_sum;
        n_msg    = r_msg;
        n_cmdb   = r_cmdb;
        n_chk    = r_chk;
        n_cmd    = r_cmd;
        n_bytes  = r_bytes;
        n_good   = r_good;
        n_tail   = r_tail;
        n_msgbad = r_msgbad;
        n_sumbad = r_sumbad;
        status   = ST_NONE;
        if (i_push) begin
            if (i_func) begin
                n_bytes  = CntZero;
                n_good   = CntZero;
                n_tail   = CntZero;
                n_msgbad = CntZero;
                n_sumbad = CntZero;
                n_cmd    = PAD_BYTE;
            end else begin
                n_bytes = r_bytes + CntOne;
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_rx_byte == i_cfg.hdr1) begin
                            n_sum   = i_rx_byte;
                            n_phase = PH_HEAD2;
                        end
                    end
                    PH_HEAD2: begin
                        if (i_rx_byte == i_cfg.hdr2_rx) begin
                            n_sum   = r_sum + i_rx_byte;
                            n_fill  = FillFirst;
                            n_phase = PH_DATA;
                        end else if (i_rx_byte == i_cfg.hdr1) begin
                            n_sum = i_rx_byte;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        n_fill = r_fill + 3'd1;
                        if (r_fill <= FillSum) begin
                            n_sum = r_sum + i_rx_byte;
                        end
                        if (r_fill == FillMsg) begin
                            n_msg = i_rx_byte;
                        end
                        if (r_fill == FillCmd) begin
                            n_cmdb = i_rx_byte;
                        end
                        if (r_fill == FillChk) begin
                            n_chk = i_rx_byte;
                        end
                        if (r_fill == FillEnd) begin
                            n_phase = PH_IDLE;
                            if (i_rx_byte != i_cfg.tail) begin
                                n_tail = r_tail + CntOne;
                                status = ST_BAD_TAIL;
                            end else if (r_msg != i_cfg.msg_rx) begin
                                n_msgbad = r_msgbad + CntOne;
                                status   = ST_BAD_MSG;
                            end else if (r_sum != r_chk) begin
                                n_sumbad = r_sumbad + CntOne;
                                status   = ST_BAD_SUM;
                            end else begin
                                n_cmd  = r_cmdb;
                                n_good = r_good + CntOne;
                                status = ST_VALID;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_fill   <= 3'd0;
            r_cmd    <= PAD_BYTE;
            r_bytes  <= CntZero;
            r_good   <= CntZero;
            r_tail   <= CntZero;
            r_msgbad <= CntZero;
            r_sumbad <= CntZero;
        end else begin
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_cmd    <= n_cmd;
            r_bytes  <= n_bytes;
            r_good   <= n_good;
            r_tail   <= n_tail;
            r_msgbad <= n_msgbad;
            r_sumbad <= n_sumbad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_msg  <= n_msg;
        r_cmdb <= n_cmdb;
        r_chk  <= n_chk;
    end

    assign o_ctl.status = status;
    assign o_ctl.cmd    = n_cmd;
    assign o_cnt        = {n_sumbad, n_msgbad, n_tail, n_good, n_bytes};

    // data collection always starts past the two header bytes
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_fill != 3'd0 && r_fill != 3'd1))
        else $error("fill position below first data byte");

    a_good_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_func && status == ST_VALID) |=> (r_good == $past(r_good) + CntOne))
        else $error("valid frame not counted");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_func) |=> (r_bytes == CntZero && r_cmd == PAD_BYTE && r_good == CntZero))
        else $error("clear left statistics behind");

endmodule

`default_nettype wire

// ===== hdl/sfp_queue.sv =====
// ---------------------------------------------------------------------------
// sfp_queue
// two-entry job queue between frame checker and reply sequencer
// ---------------------------------------------------------------------------
`default_nettype none

module sfp_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    input  wire logic              i_pop
);
    logic [DATA_W-1:0] r_mem [0:1];
    logic              r_wptr, r_rptr;
    logic [1:0]        r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

endmodule

`default_nettype wire

// ===== hdl/sfp_back.sv =====
// ---------------------------------------------------------------------------
// sfp_back
// result sequencer: one status transaction or an eight-byte reply frame
// ---------------------------------------------------------------------------
`default_nettype none

module sfp_back #(
    parameter int W = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire sfp_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_job_valid,
    input  wire sfp_pkg::t_job_ctl                  i_job_ctl,
    input  wire logic [sfp_pkg::NUM_CNT*W-1:0]      i_job_cnt,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [7:0]                              o_tx_byte,
    output logic                                    o_tx_valid,
    output logic                                    o_last,
    output logic [2:0]                              o_frame_status,
    output logic [7:0]                              o_command_id,
    output logic [sfp_pkg::CNT_OUT_W-1:0]           o_byte_count,
    output logic [sfp_pkg::CNT_OUT_W-1:0]           o_valid_count,
    output logic [sfp_pkg::CNT_OUT_W-1:0]           o_bad_tail_count,
    output logic [sfp_pkg::CNT_OUT_W-1:0]           o_bad_msg_count,
    output logic [sfp_pkg::CNT_OUT_W-1:0]           o_bad_sum_count
);
    import sfp_pkg::*;

    localparam logic [2:0] IdxLast = 3'd7;

    logic                 r_busy;
    logic [2:0]           r_idx;
    t_job_ctl             r_ctl;
    logic [NUM_CNT*W-1:0] r_cnt;
    logic                 is_reply;
    logic                 done;
    logic [7:0]           reply_sum;
    logic [7:0]           reply_byte;

    assign is_reply  = (r_ctl.status == ST_VALID);
    assign o_last    = !is_reply || (r_idx == IdxLast);
    assign done      = r_busy && i_ready && o_last;
    assign o_pop     = i_job_valid && (!r_busy || done);
    assign reply_sum = i_cfg.hdr1 + i_cfg.hdr2_tx + i_cfg.msg_tx + r_ctl.cmd;

    always_comb begin
        unique case (r_idx)
            3'd0:    reply_byte = i_cfg.hdr1;
            3'd1:    reply_byte = i_cfg.hdr2_tx;
            3'd2:    reply_byte = PAD_BYTE;
            3'd3:    reply_byte = i_cfg.msg_tx;
            3'd4:    reply_byte = r_ctl.cmd;
            3'd5:    reply_byte = PAD_BYTE;
            3'd6:    reply_byte = reply_sum;
            default: reply_byte = i_cfg.tail;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl <= i_job_ctl;
            r_cnt <= i_job_cnt;
        end
    end

    assign o_valid          = r_busy;
    assign o_tx_valid       = is_reply;
    assign o_tx_byte        = is_reply ? reply_byte : PAD_BYTE;
    assign o_frame_status   = r_ctl.status;
    assign o_command_id     = r_ctl.cmd;
    assign o_byte_count     = CNT_OUT_W'(r_cnt[0*W +: W]);
    assign o_valid_count    = CNT_OUT_W'(r_cnt[1*W +: W]);
    assign o_bad_tail_count = CNT_OUT_W'(r_cnt[2*W +: W]);
    assign o_bad_msg_count  = CNT_OUT_W'(r_cnt[3*W +: W]);
    assign o_bad_sum_count  = CNT_OUT_W'(r_cnt[4*W +: W]);

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last && !i_job_valid) |=> !o_valid)
        else $error("output stays valid after final transaction");

    a_reply_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tx_valid && !o_last && i_ready) |=> (o_valid && o_tx_valid))
        else $error("reply frame cut short");

endmodule

`default_nettype wire
